// ===== rtl/servo_sweep_with_code_unlock_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the servo sweep sequencer
// Shared property shapes, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SERVO_SWEEP_WITH_CODE_UNLOCK_ASSERT_SVH
`define SERVO_SWEEP_WITH_CODE_UNLOCK_ASSERT_SVH

// same-cycle implication
`define SSU_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("ssu same-cycle check failed");

// next-cycle implication
`define SSU_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("ssu next-cycle check failed");

`endif

// ===== rtl/ssu_pkg.sv =====
// ----------------------------------------------------------------------------
// ssu_pkg
// Types, codes and constants shared by the servo sweep sequencer.
// ----------------------------------------------------------------------------
package ssu_pkg;

  localparam int unsigned CODE_DIGITS = 4;
  localparam int unsigned CNT_W       = 3;

  localparam logic [1:0] CMD_TIMER  = 2'd0;
  localparam logic [1:0] CMD_KEY    = 2'd1;
  localparam logic [1:0] CMD_SERIAL = 2'd2;

  localparam logic [4:0] KEY_CLEAR = 5'd16;
  localparam logic [4:0] KEY_ENTER = 5'd13;
  localparam logic [4:0] KEY_FIRST = 5'd1;
  localparam logic [4:0] KEY_LAST  = 5'd15;

  localparam logic [7:0] SER_UP   = 8'h81;
  localparam logic [7:0] SER_DOWN = 8'h82;

  localparam logic [16:0] FREE_RUN = 17'd65536;

  typedef enum logic [2:0] {
    REG_UNLOCK_CODE = 3'd0,
    REG_RAMP_STEP   = 3'd1,
    REG_WIDTH_MIN   = 3'd2,
    REG_WIDTH_MAX   = 3'd3,
    REG_HALF_FRAME  = 3'd4,
    REG_REST        = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    K_TIMER  = 2'd0,
    K_KEY    = 2'd1,
    K_SERIAL = 2'd2,
    K_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2,
    PH_REST  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [15:0] unlock_code;
    logic [7:0]  ramp_step;
    logic [12:0] width_min;
    logic [12:0] width_max;
    logic [15:0] half_frame;
    logic [15:0] rest_interval;
  } cfg_t;

  // classified item as it travels through the queue
  typedef struct packed {
    kind_t      kind;
    logic       key_clear;
    logic       key_digit;
    logic       key_enter;
    logic [3:0] digit;
    logic       ser_up;
    logic       ser_down;
    logic [7:0] echo;
  } item_t;

endpackage

// ===== rtl/ssu_regs.sv =====
// ----------------------------------------------------------------------------
// ssu_regs
// APB-style configuration registers with reset defaults.
// ----------------------------------------------------------------------------
module ssu_regs
  import ssu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.unlock_code   <= 16'h1234;
      cfg.ramp_step     <= 8'd10;
      cfg.width_min     <= 13'd500;
      cfg.width_max     <= 13'd2500;
      cfg.half_frame    <= 16'd5000;
      cfg.rest_interval <= 16'd10000;
    end else if (wr_en) begin
      case (idx)
        REG_UNLOCK_CODE: cfg.unlock_code   <= pwdata[15:0];
        REG_RAMP_STEP:   cfg.ramp_step     <= pwdata[7:0];
        REG_WIDTH_MIN:   cfg.width_min     <= pwdata[12:0];
        REG_WIDTH_MAX:   cfg.width_max     <= pwdata[12:0];
        REG_HALF_FRAME:  cfg.half_frame    <= pwdata[15:0];
        REG_REST:        cfg.rest_interval <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_UNLOCK_CODE: prdata = {16'd0, cfg.unlock_code};
      REG_RAMP_STEP:   prdata = {24'd0, cfg.ramp_step};
      REG_WIDTH_MIN:   prdata = {19'd0, cfg.width_min};
      REG_WIDTH_MAX:   prdata = {19'd0, cfg.width_max};
      REG_HALF_FRAME:  prdata = {16'd0, cfg.half_frame};
      REG_REST:        prdata = {16'd0, cfg.rest_interval};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/ssu_front.sv =====
// ----------------------------------------------------------------------------
// ssu_front
// Takes input transfers and classifies them for the execution side.
// ----------------------------------------------------------------------------
module ssu_front
  import ssu_pkg::*;
(
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] command,
  input  logic [4:0] key_code,
  input  logic [7:0] serial_byte,
  input  logic       q_full,
  output logic       push,
  output item_t      item
);

  assign in_stall = q_full;
  assign push     = in_valid & ~q_full;

  always_comb begin
    case (command)
      CMD_TIMER:  item.kind = K_TIMER;
      CMD_KEY:    item.kind = K_KEY;
      CMD_SERIAL: item.kind = K_SERIAL;
      default:    item.kind = K_NONE;
    endcase
    item.key_clear = (key_code == KEY_CLEAR);
    item.key_digit = (key_code >= KEY_FIRST) && (key_code <= KEY_LAST);
    item.key_enter = (key_code == KEY_ENTER);
    item.digit     = key_code[3:0];
    item.ser_up    = (serial_byte == SER_UP);
    item.ser_down  = (serial_byte == SER_DOWN);
    item.echo      = serial_byte + 8'd1;
  end

endmodule

// ===== rtl/ssu_queue.sv =====
// ----------------------------------------------------------------------------
// ssu_queue
// Two-entry queue of classified items between front and execution.
// ----------------------------------------------------------------------------
module ssu_queue
  import ssu_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  full,
  output logic  q_valid,
  output item_t q_item
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/ssu_exec.sv =====
// ----------------------------------------------------------------------------
// ssu_exec
// Applies one queued item per cycle while not stalled to the sweep, phase
// and code-entry state and holds the result in the output register.
// ----------------------------------------------------------------------------
module ssu_exec
  import ssu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        pin_level,
  output logic [16:0] interval_us,
  output logic        interval_valid,
  output logic [15:0] entered_code,
  output logic        echo_valid,
  output logic [7:0]  echo_byte,
  output logic [12:0] width_now
);

  logic [12:0]      pulse_width;
  dir_t             sweep_dir;
  phase_t           phase;
  logic             pin_state;
  logic [15:0]      code_acc;
  logic [CNT_W-1:0] digit_count;

  logic [12:0]      pulse_width_next;
  dir_t             sweep_dir_next;
  phase_t           phase_next;
  logic             pin_state_next;
  logic [15:0]      code_acc_next;
  logic [CNT_W-1:0] digit_count_next;
  logic [16:0]      iv;

  logic             is_timer;
  logic [13:0]      w_up;
  logic [13:0]      w_dn;
  logic [13:0]      w_step;
  logic [13:0]      w_hi;
  logic             hit_max;
  logic             hit_min;
  logic [15:0]      low_iv;
  logic             digit_ok;
  logic [15:0]      acc1;
  logic [CNT_W-1:0] cnt1;
  logic             enter_hit;

  assign pop      = q_valid & (~out_valid | ~out_stall);
  assign is_timer = (q_item.kind == K_TIMER);

  // ramp and clamp: upper limit tested first, then the lower one
  always_comb begin
    w_up = {1'b0, pulse_width} + {6'd0, cfg.ramp_step};
    w_dn = (pulse_width >= {5'd0, cfg.ramp_step}) ?
           {1'b0, pulse_width - {5'd0, cfg.ramp_step}} : 14'd0;
    case (sweep_dir)
      DIR_UP:   w_step = w_up;
      DIR_DOWN: w_step = w_dn;
      default:  w_step = {1'b0, pulse_width};
    endcase
    hit_max = (w_step >= {1'b0, cfg.width_max});
    w_hi    = hit_max ? {1'b0, cfg.width_max} : w_step;
    hit_min = (w_hi <= {1'b0, cfg.width_min});
  end

  // code entry
  always_comb begin
    digit_ok  = q_item.key_digit && (digit_count < CNT_W'(CODE_DIGITS));
    acc1      = code_acc;
    cnt1      = digit_count;
    if (q_item.key_clear) begin
      acc1 = 16'd0;
      cnt1 = '0;
    end else if (digit_ok) begin
      acc1 = {code_acc[11:0], q_item.digit};
      cnt1 = digit_count + CNT_W'(1);
    end
    enter_hit = (cnt1 == CNT_W'(CODE_DIGITS)) && q_item.key_enter;
  end

  // next state
  always_comb begin
    pulse_width_next = pulse_width;
    sweep_dir_next   = sweep_dir;
    phase_next       = phase;
    code_acc_next    = code_acc;
    digit_count_next = digit_count;
    case (q_item.kind)
      K_TIMER: begin
        pulse_width_next = hit_min ? cfg.width_min : w_hi[12:0];
        if (hit_max || hit_min) sweep_dir_next = DIR_STOP;
        case (phase)
          PH_HIGH: phase_next = PH_LOW;
          PH_LOW:  phase_next = PH_REST;
          default: phase_next = PH_HIGH;
        endcase
      end
      K_KEY: begin
        code_acc_next    = acc1;
        digit_count_next = cnt1;
        if (q_item.key_clear) sweep_dir_next = DIR_UP;
        if (enter_hit) begin
          if (acc1 == cfg.unlock_code) sweep_dir_next = DIR_DOWN;
          code_acc_next    = 16'd0;
          digit_count_next = '0;
        end
      end
      K_SERIAL: begin
        if (q_item.ser_up)        sweep_dir_next = DIR_UP;
        else if (q_item.ser_down) sweep_dir_next = DIR_DOWN;
      end
      default: ;
    endcase
  end

  // pin and interval per phase
  always_comb begin
    low_iv = (cfg.half_frame > {3'd0, pulse_width_next}) ?
             cfg.half_frame - {3'd0, pulse_width_next} : 16'd0;
    pin_state_next = pin_state;
    iv             = 17'd0;
    if (is_timer) begin
      case (phase)
        PH_HIGH: begin
          pin_state_next = 1'b1;
          iv             = {4'd0, pulse_width_next};
        end
        PH_LOW: begin
          pin_state_next = 1'b0;
          iv             = {1'b0, low_iv};
        end
        PH_REST: iv = {1'b0, cfg.rest_interval};
        default: iv = FREE_RUN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_width <= 13'd2000;
      sweep_dir   <= DIR_STOP;
      phase       <= PH_START;
      pin_state   <= 1'b1;
      code_acc    <= 16'd0;
      digit_count <= '0;
    end else if (pop) begin
      pulse_width <= pulse_width_next;
      sweep_dir   <= sweep_dir_next;
      phase       <= phase_next;
      pin_state   <= pin_state_next;
      code_acc    <= code_acc_next;
      digit_count <= digit_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pin_level      <= pin_state_next;
      interval_us    <= iv;
      interval_valid <= is_timer;
      entered_code   <= code_acc_next;
      echo_valid     <= (q_item.kind == K_SERIAL);
      echo_byte      <= (q_item.kind == K_SERIAL) ? q_item.echo : 8'd0;
      width_now      <= pulse_width_next;
    end
  end

`include "servo_sweep_with_code_unlock_assert.svh"

  `SSU_ASSERT_NOW(a_digit_bound, 1'b1, digit_count <= CNT_W'(CODE_DIGITS))
  `SSU_ASSERT_NEXT(a_phase_left_start, pop && is_timer, phase != PH_START)
  `SSU_ASSERT_NEXT(a_result_follows_pop, pop, out_valid)
  `SSU_ASSERT_NOW(a_pop_needs_room, pop, !out_valid || !out_stall)

endmodule

// ===== rtl/servo_sweep_with_code_unlock.sv =====
// ----------------------------------------------------------------------------
// servo_sweep_with_code_unlock
// Servo pulse sequencer: timer events ramp and clamp the pulse width and
// step the high / low / rest phases; key presses build a hex unlock code
// and steer the sweep; serial bytes steer it too and are echoed plus one.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake             payload
//  -------   ---  --------------------  -----------------------------------
//  input     in   in_valid / in_stall   command, key_code, serial_byte
//  result    out  out_valid / out_stall pin_level, interval_us,
//                                       interval_valid, entered_code,
//                                       echo_valid, echo_byte, width_now
//  config    in   APB (psel/penable)    paddr, pwdata, prdata, pready
//
//  - One item per clock sustained while out_stall is low; a result passes
//    through two registers after its input transfer (the queue slot, then
//    the execution output register) before it can transfer.
//  - The execution stage does the whole ramp, clamp, phase and code-entry
//    update combinationally, so back-to-back items chain through its state.
//  - A two-entry queue separates front and execution; in_stall rises only
//    when it is full, out_stall holds the output register and backs up the
//    queue.
//  - rst is synchronous, active high; it restores register defaults and
//    the state: width 2000, sweep stopped, start phase, pin high.
//
module servo_sweep_with_code_unlock
  import ssu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [4:0]  key_code,
  input  logic [7:0]  serial_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        pin_level,
  output logic [16:0] interval_us,
  output logic        interval_valid,
  output logic [15:0] entered_code,
  output logic        echo_valid,
  output logic [7:0]  echo_byte,
  output logic [12:0] width_now,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t  cfg;
  item_t front_item;
  item_t q_item;
  logic  push;
  logic  pop;
  logic  q_full;
  logic  q_valid;

  // the user must write registers only while the block is idle; the block does not enforce this
  ssu_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // decode the command and key/byte into flags
  ssu_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .key_code    (key_code),
    .serial_byte (serial_byte),
    .q_full      (q_full),
    .push        (push),
    .item        (front_item)
  );

  ssu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  // state update and output register
  ssu_exec u_exec (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .pin_level      (pin_level),
    .interval_us    (interval_us),
    .interval_valid (interval_valid),
    .entered_code   (entered_code),
    .echo_valid     (echo_valid),
    .echo_byte      (echo_byte),
    .width_now      (width_now)
  );

endmodule
